@@ hdl/fba_pkg.sv @@
// Shared constants, command and status codes for the block allocator.
// Depends on nothing; the interfaces and the top level import it.
package fba_pkg;

  localparam int CMD_W      = 3;
  localparam int ST_W       = 2;
  localparam int BLK_W      = 8;
  localparam int CNT_W      = 9;
  localparam int LINK_DEPTH = 256;
  localparam int GRP_SIZE   = 8;
  localparam int SUB_W      = 3;
  localparam int GRP_N      = LINK_DEPTH / GRP_SIZE;
  localparam int GRP_W      = 5;
  localparam int RESERVED   = 3;

  localparam int NUM_BLOCKS_DEF = 256;

  localparam logic [CMD_W-1:0] CMD_FORMAT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LAST   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_LOOP = 2'd2;

  localparam logic [BLK_W-1:0] LINK_END  = 8'd0;
  localparam logic [BLK_W-1:0] LINK_FREE = 8'd1;

  typedef logic [LINK_DEPTH-1:0] bitmap_t;

  // Free bitmap after format: every real block free except the reserved ones.
  function automatic bitmap_t free_init(input int nb);
    bitmap_t v;
    v = '0;
    for (int i = 0; i < LINK_DEPTH; i++) begin
      v[i] = (i >= RESERVED) && (i < nb);
    end
    return v;
  endfunction

endpackage

@@ hdl/fba_cmd_if.sv @@
// Request channel of the block allocator: valid/ready plus command payload.
// Depends on fba_pkg.
interface fba_cmd_if;
  import fba_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [BLK_W-1:0] block_arg;
  logic             link_prev;

  modport source (output valid, cmd, block_arg, link_prev, input ready);
  modport sink   (input valid, cmd, block_arg, link_prev, output ready);
endinterface

@@ hdl/fba_res_if.sv @@
// Result channel of the block allocator: valid/ready plus result payload.
// Depends on fba_pkg.
interface fba_res_if;
  import fba_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [BLK_W-1:0] block_out;
  logic             end_of_chain;
  logic [CNT_W-1:0] freed_count;

  modport source (output valid, status, block_out, end_of_chain, freed_count, input ready);
  modport sink   (input valid, status, block_out, end_of_chain, freed_count, output ready);
endinterface

@@ hdl/fba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/fat_block_allocator.sv @@
// Top level of the block allocator: link table, free bitmap and command sequencer.
// Depends on fba_pkg, fba_cmd_if, fba_res_if and fba_ram.
//
//   Channel  Direction  Payload
//   req      in         cmd, block_arg, link_prev
//   rsp      out        status, block_out, end_of_chain, freed_count
//
// Each request runs alone through the sequencer. Format and unused codes
// load their result straight away; allocate finds a free group, then the
// bit in it, then writes the links (none when the disk is full); next reads
// one link; free chain and last of chain read one link per block. The walks
// use the single link RAM, which is read and written in separate cycles.
// Reset (synchronous, rst high) formats the table at once; no clearing pass.
// The result sits in an output register, so a new request is taken while
// the previous result still waits; a stalled result only holds the sequencer
// in its final state.
module fat_block_allocator #(
  parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
  input logic clk,
  input logic rst,
  fba_cmd_if.sink   req,
  fba_res_if.source rsp
);
  import fba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRP  = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_ALW  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WT   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam bitmap_t          FREE_INIT = free_init(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] NB        = CNT_W'(NUM_BLOCKS);

  logic [2:0]       state;

  // Request captured at acceptance.
  logic [CMD_W-1:0] cmd_q;
  logic [BLK_W-1:0] arg_q;
  logic             lnk_q;

  // Working registers of the walk and the allocate search.
  logic [BLK_W-1:0] blk;
  logic [CNT_W-1:0] cnt;
  logic [GRP_W-1:0] grp_idx;
  logic             grp_found;

  // The link table lives in RAM; an entry whose valid bit is clear reads as
  // the free marker, which lets format and reset clear it without a RAM pass.
  bitmap_t          link_valid;
  bitmap_t          free_bits;

  // Result being built, then the output register.
  logic [ST_W-1:0]  res_status;
  logic [BLK_W-1:0] res_block;
  logic             res_eoc;
  logic [CNT_W-1:0] res_freed;

  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [BLK_W-1:0] out_block;
  logic             out_eoc;
  logic [CNT_W-1:0] out_freed;

  logic             ram_we;
  logic [BLK_W-1:0] ram_waddr;
  logic [BLK_W-1:0] ram_wdata;
  logic             ram_re;
  logic [BLK_W-1:0] ram_rdata;

  logic [GRP_N-1:0] grp_any;
  logic [GRP_W-1:0] first_grp;
  logic             any_found;
  logic [GRP_SIZE-1:0] grp_bits;
  logic [SUB_W-1:0] first_bit;
  logic [BLK_W-1:0] new_blk;
  logic [BLK_W-1:0] nxt;
  logic             free_limit;
  logic             blk_real;

  fba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (blk),
    .rdata (ram_rdata)
  );

  // First stage of the lowest-free search: which group of eight holds a free
  // block. The second stage picks the bit inside the registered group.
  always_comb begin
    first_grp = '0;
    any_found = 1'b0;
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |free_bits[g*GRP_SIZE +: GRP_SIZE];
    end
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        first_grp = GRP_W'(g);
        any_found = 1'b1;
      end
    end
  end

  always_comb begin
    grp_bits  = free_bits[{grp_idx, {SUB_W{1'b0}}} +: GRP_SIZE];
    first_bit = '0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        first_bit = SUB_W'(b);
      end
    end
    new_blk = {grp_idx, first_bit};
  end

  // Link read back from the RAM in the cycle after the read in S_RD.
  assign nxt        = link_valid[blk] ? ram_rdata : LINK_FREE;
  assign free_limit = (cmd_q == CMD_FREE) && (cnt >= NB);
  assign blk_real   = {1'b0, blk} < NB;

  assign ram_re = (state == S_RD) && !free_limit;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = blk;
    ram_wdata = LINK_END;
    case (state)
      S_BIT: begin
        ram_we    = grp_found && lnk_q;
        ram_waddr = arg_q;
        ram_wdata = new_blk;
      end
      S_ALW: begin
        ram_we = 1'b1;
      end
      S_WT: begin
        ram_we    = (cmd_q == CMD_FREE);
        ram_wdata = LINK_FREE;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      link_valid <= '0;
      free_bits  <= FREE_INIT;
      out_valid  <= 1'b0;
    end else begin
      // In S_DONE the output register is handled by the state itself.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q      <= req.cmd;
            arg_q      <= req.block_arg;
            lnk_q      <= req.link_prev;
            blk        <= req.block_arg;
            cnt        <= '0;
            res_status <= ST_OK;
            res_block  <= '0;
            res_eoc    <= 1'b0;
            res_freed  <= '0;
            case (req.cmd)
              CMD_FORMAT: begin
                link_valid <= '0;
                free_bits  <= FREE_INIT;
                state      <= S_DONE;
              end
              CMD_ALLOC: begin
                state <= S_GRP;
              end
              CMD_FREE: begin
                // A chain that starts at the free marker is left alone.
                state <= (req.block_arg == LINK_FREE) ? S_DONE : S_RD;
              end
              CMD_NEXT, CMD_LAST: begin
                state <= S_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_GRP: begin
          grp_idx   <= first_grp;
          grp_found <= any_found;
          state     <= S_BIT;
        end
        S_BIT: begin
          if (grp_found) begin
            blk                <= new_blk;
            free_bits[new_blk] <= 1'b0;
            res_block          <= new_blk;
            if (lnk_q) begin
              link_valid[arg_q] <= 1'b1;
            end
            state <= S_ALW;
          end else begin
            res_status <= ST_FULL;
            res_block  <= LINK_FREE;
            state      <= S_DONE;
          end
        end
        S_ALW: begin
          // The new block's end link goes in after the previous-block link.
          link_valid[blk] <= 1'b1;
          state           <= S_DONE;
        end
        S_RD: begin
          if (free_limit) begin
            res_status <= ST_LOOP;
            res_freed  <= cnt;
            state      <= S_DONE;
          end else begin
            state <= S_WT;
          end
        end
        S_WT: begin
          case (cmd_q)
            CMD_NEXT: begin
              res_block <= nxt;
              res_eoc   <= (nxt == LINK_END);
              state     <= S_DONE;
            end
            CMD_FREE: begin
              link_valid[blk] <= 1'b1;
              if (blk_real) begin
                free_bits[blk] <= 1'b1;
              end
              cnt <= cnt + 1'b1;
              if (nxt == LINK_END) begin
                res_freed <= cnt + 1'b1;
                state     <= S_DONE;
              end else begin
                blk   <= nxt;
                state <= S_RD;
              end
            end
            default: begin
              if (nxt == LINK_END) begin
                res_eoc   <= 1'b1;
                res_block <= blk;
                state     <= S_DONE;
              end else if (cnt >= NB) begin
                res_status <= ST_LOOP;
                res_block  <= blk;
                state      <= S_DONE;
              end else begin
                blk   <= nxt;
                cnt   <= cnt + 1'b1;
                state <= S_RD;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_block  <= res_block;
            out_eoc    <= res_eoc;
            out_freed  <= res_freed;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.block_out    = out_block;
  assign rsp.end_of_chain = out_eoc;
  assign rsp.freed_count  = out_freed;

  // The link RAM is never read and written in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(ram_re && ram_we))
    else $error("link RAM read and write collide");

  // A link is only consumed in the cycle after its read.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WT) |-> ($past(state) == S_RD))
    else $error("link used without a preceding read");

  // Walk counters never pass the block count.
  assert property (@(posedge clk) disable iff (rst) (cnt <= NB) || (state == S_IDLE))
    else $error("walk counter beyond block count");

  // An allocated block is a real block and has just left the free bitmap.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ALW) |-> (blk_real && !free_bits[blk]))
    else $error("allocated block not real or still free");

endmodule
